// ===== hw/rtl/ckt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the counted key table
// no dependencies; used by ckt_entry, counted_key_table and the testbench
package ckt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int COUNT_BITS_DEF    = 16;
	localparam int KEY_W             = 32;
	localparam int REPORT_W          = 16;
	localparam int STATUS_W          = 2;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	// per-entry update; at most one member is set
	typedef struct packed {
		logic alloc;
		logic bump;
		logic drop;
	} entry_ctl_t;

endpackage

// ===== hw/rtl/ckt_entry.sv =====
`timescale 1ns / 1ps
// one table entry: stored key, occurrence count, valid bit and key compare
// depends on ckt_pkg
module ckt_entry #(
	parameter int COUNT_BITS = ckt_pkg::COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ckt_pkg::KEY_W-1:0] key,
	input  ckt_pkg::entry_ctl_t      ctl,
	output logic                     hit,
	output logic                     valid,
	output logic [COUNT_BITS-1:0]    count
);
	import ckt_pkg::*;

	logic [KEY_W-1:0]      key_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (ctl.alloc) begin
			valid_q <= 1'b1;
			count_q <= COUNT_BITS'(1);
		end else if (ctl.bump) begin
			count_q <= count_q + COUNT_BITS'(1);
		end else if (ctl.drop) begin
			if (count_q <= COUNT_BITS'(1)) begin
				valid_q <= 1'b0;
				count_q <= '0;
			end else begin
				count_q <= count_q - COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.alloc) begin
			key_q <= key;
		end
	end

	assign hit   = valid_q && (key_q == key);
	assign valid = valid_q;
	assign count = count_q;

endmodule

// ===== hw/rtl/counted_key_table.sv =====
`timescale 1ns / 1ps
// counted key table: fully associative key store with per-key occurrence counts
// a taken request is held in the input register, and its result in the result register
// throughput: one request per cycle when the output is not stalled; the compare over all
// entries and the count update sit between the input register and the result register
// reset: asynchronous, table empty at once, no clearing pass
// depends on ckt_pkg and ckt_entry
module counted_key_table #(
	parameter int TABLE_ENTRIES = ckt_pkg::TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS    = ckt_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ckt_pkg::KEY_W-1:0]      s_tdata,   // [31:0] key
	input  logic [0:0]                    s_tuser,   // [0] cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ckt_pkg::REPORT_W-1:0]   m_tdata,   // [15:0] count_after
	output logic [ckt_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);
	import ckt_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// input register
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [KEY_W-1:0] key_s1;

	// result register
	logic                valid_s2;
	status_t             status_s2;
	logic [REPORT_W-1:0] count_s2;

	logic                       adv;
	logic                       fire;
	logic                       take;
	logic [TABLE_ENTRIES-1:0]   hit_vec;
	logic [TABLE_ENTRIES-1:0]   valid_vec;
	logic [TABLE_ENTRIES-1:0]   free_vec;
	logic [TABLE_ENTRIES-1:0]   free_first;
	logic [COUNT_BITS-1:0]      cnt_arr [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0]      sel_cnt;
	logic                       any_hit;
	logic                       any_free;
	logic                       do_alloc;
	logic                       do_bump;
	logic                       do_drop;
	status_t                    status_d;
	logic [COUNT_BITS-1:0]      after_d;
	logic [REPORT_W-1:0]        report_d;
	entry_ctl_t                 ctl_arr [TABLE_ENTRIES];

	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_entry
			assign ctl_arr[gi].alloc = do_alloc && free_first[gi];
			assign ctl_arr[gi].bump  = do_bump && hit_vec[gi];
			assign ctl_arr[gi].drop  = do_drop && hit_vec[gi];

			ckt_entry #(
				.COUNT_BITS(COUNT_BITS)
			) u_entry (
				.clk   (clk),
				.arst_n(arst_n),
				.key   (key_s1),
				.ctl   (ctl_arr[gi]),
				.hit   (hit_vec[gi]),
				.valid (valid_vec[gi]),
				.count (cnt_arr[gi])
			);
		end
	endgenerate

	// lowest free entry
	assign free_vec   = ~valid_vec;
	assign free_first = free_vec & (~free_vec + TABLE_ENTRIES'(1));
	assign any_free   = |free_vec;
	assign any_hit    = |hit_vec;

	// keys are unique, so at most one entry hits
	always_comb begin
		sel_cnt = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sel_cnt = sel_cnt | (cnt_arr[i] & {COUNT_BITS{hit_vec[i]}});
		end
	end

	always_comb begin
		do_alloc = 1'b0;
		do_bump  = 1'b0;
		do_drop  = 1'b0;
		status_d = ST_OK;
		after_d  = '0;
		unique case (cmd_s1)
			CMD_INSERT: begin
				if (any_hit) begin
					if (sel_cnt == COUNT_MAX) begin
						status_d = ST_SATURATED;
						after_d  = COUNT_MAX;
					end else begin
						do_bump = fire;
						after_d = sel_cnt + COUNT_BITS'(1);
					end
				end else if (any_free) begin
					do_alloc = fire;
					after_d  = COUNT_BITS'(1);
				end else begin
					status_d = ST_FULL;
				end
			end
			CMD_REMOVE: begin
				if (any_hit) begin
					do_drop = fire;
					if (sel_cnt > COUNT_BITS'(1)) begin
						after_d = sel_cnt - COUNT_BITS'(1);
					end
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// counts wider than the report field saturate
	generate
		if (COUNT_BITS > REPORT_W) begin : g_rep_sat
			assign report_d = (|after_d[COUNT_BITS-1:REPORT_W]) ? {REPORT_W{1'b1}}
				: after_d[REPORT_W-1:0];
		end else begin : g_rep_ext
			assign report_d = REPORT_W'(after_d);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_t'(s_tuser[0]);
			key_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_d;
			count_s2  <= report_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = count_s2;
	assign m_tuser  = status_s2;

	// a key is held by one entry at most
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key held by more than one entry");

	// allocation fills exactly one more entry
	a_alloc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		do_alloc |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
		else $error("allocation did not fill one entry");

	// removing the last occurrence frees exactly one entry
	a_drop_free: assert property (@(posedge clk) disable iff (!arst_n)
		(do_drop && (sel_cnt <= COUNT_BITS'(1)))
		|=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
		else $error("last remove did not free one entry");

	// a removal that leaves the key present keeps the occupancy
	a_drop_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(do_drop && (sel_cnt > COUNT_BITS'(1))) |=> $stable(valid_vec))
		else $error("partial remove changed occupancy");

endmodule

// ===== sim/counted_key_table_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for counted_key_table: directed, table-fill and random
// request streams with a built-in table predictor checked against every result
// depends on ckt_pkg and the counted_key_table rtl
module counted_key_table_tb;
	import ckt_pkg::*;

	localparam int  POOL_SIZE      = 96;
	localparam int  RX_HOLD_CYCLES = 300;
	localparam int  CYCLE_LIMIT    = 600000;
	localparam longint COUNT_MAX   = (longint'(1) << COUNT_BITS_DEF) - 1;

	typedef struct packed {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
	} table_req_t;

	typedef struct packed {
		status_t             status;
		logic [REPORT_W-1:0] count_after;
	} table_resp_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [KEY_W-1:0]    s_tdata  = '0;   // [31:0] key
	logic [0:0]          s_tuser  = '0;   // [0] cmd
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [REPORT_W-1:0] m_tdata;         // [15:0] count_after
	logic [STATUS_W-1:0] m_tuser;         // [1:0] status

	table_req_t  pending_reqs[$];
	table_resp_t expected_resps[$];

	// predictor copy of the table
	logic [KEY_W-1:0]          slot_key[TABLE_ENTRIES_DEF];
	logic [COUNT_BITS_DEF-1:0] slot_count[TABLE_ENTRIES_DEF];
	logic                      slot_used[TABLE_ENTRIES_DEF];

	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	logic req_taken    = 1'b0;
	bit   gaps_on      = 1'b1;
	int   rx_hold_kick = 0;
	int   rx_hold_seen = 0;
	int   rx_hold_left = 0;
	int   cycle_cnt    = 0;
	int   fail_cnt     = 0;

	counted_key_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic table_resp_t apply_request(cmd_t cmd, logic [KEY_W-1:0] key);
		table_resp_t r;
		int          hit;
		int          free_slot;
		longint      after;
		hit       = -1;
		free_slot = -1;
		after     = 0;
		r.status  = ST_OK;
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			if (slot_used[i] && slot_key[i] == key && hit < 0)
				hit = i;
			if (!slot_used[i] && free_slot < 0)
				free_slot = i;
		end
		if (cmd == CMD_INSERT) begin
			if (hit < 0) begin
				if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_key[free_slot]   = key;
					slot_count[free_slot] = COUNT_BITS_DEF'(1);
					slot_used[free_slot]  = 1'b1;
					after = 1;
				end
			end else if (slot_count[hit] >= COUNT_MAX) begin
				r.status = ST_SATURATED;
				after = longint'(slot_count[hit]);
			end else begin
				slot_count[hit] = slot_count[hit] + 1'b1;
				after = longint'(slot_count[hit]);
			end
		end else begin
			if (hit < 0) begin
				r.status = ST_NOT_FOUND;
			end else if (slot_count[hit] <= 1) begin
				slot_count[hit] = '0;
				slot_used[hit]  = 1'b0;
			end else begin
				slot_count[hit] = slot_count[hit] - 1'b1;
				after = longint'(slot_count[hit]);
			end
		end
		r.count_after = (after > 65535) ? 16'hFFFF : after[REPORT_W-1:0];
		return r;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (pending_reqs.size() != 0 && !(gaps_on && $urandom_range(99) < 8)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_reqs[0].key;
				s_tuser  <= pending_reqs[0].cmd;
				void'(pending_reqs.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_seen != rx_hold_kick) begin
			rx_hold_seen <= rx_hold_kick;
			rx_hold_left <= RX_HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready     <= 1'b0;
		end else begin
			m_tready <= !(gaps_on && $urandom_range(99) < 8);
		end
	end

	// monitor: check results, predict on each accepted request
	always @(posedge clk) begin : monitor
		table_resp_t want;
		req_taken <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (expected_resps.size() == 0) begin
				$display("%0t: unexpected result: status %0d count_after %0d",
					$time, m_tuser, m_tdata);
				fail_cnt++;
			end else begin
				want = expected_resps.pop_front();
				if (m_tuser !== want.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d",
						$time, want.status, m_tuser);
					fail_cnt++;
				end
				if (m_tdata !== want.count_after) begin
					$display("%0t: count_after mismatch: expected %0d actual %0d",
						$time, want.count_after, m_tdata);
					fail_cnt++;
				end
			end
		end
		if (s_tvalid && s_tready)
			expected_resps.push_back(apply_request(cmd_t'(s_tuser), s_tdata));
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_resps.size());
			$display("counted_key_table_tb NOT OK");
			$finish;
		end
	end

	task automatic push_req(cmd_t cmd, logic [KEY_W-1:0] key);
		table_req_t r;
		r.cmd = cmd;
		r.key = key;
		pending_reqs.push_back(r);
	endtask

	// sender holds back until every request is out and every result is back
	task automatic drain();
		while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random_block(int n, int insert_pct);
		logic [KEY_W-1:0] key;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 10)
				key = $urandom;
			else
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			push_req(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE, key);
		end
	endtask

	initial begin : stimulus
		int mix[8];
		mix = '{50, 75, 75, 60, 30, 25, 50, 50};
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			slot_key[i]   = '0;
			slot_count[i] = '0;
			slot_used[i]  = 1'b0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// key extremes, hits, frees and misses on an empty table
		push_req(CMD_REMOVE, 32'h0000_0000);
		push_req(CMD_INSERT, 32'h0000_0000);
		push_req(CMD_INSERT, 32'h0000_0000);
		push_req(CMD_INSERT, 32'hFFFF_FFFF);
		push_req(CMD_REMOVE, 32'h0000_0000);
		push_req(CMD_REMOVE, 32'h0000_0000);
		push_req(CMD_REMOVE, 32'h0000_0000);
		push_req(CMD_INSERT, 32'h8000_0000);
		push_req(CMD_INSERT, 32'h0000_0001);
		push_req(CMD_REMOVE, 32'hFFFF_FFFF);
		push_req(CMD_REMOVE, 32'hFFFF_FFFF);
		push_req(CMD_INSERT, 32'h5555_5555);
		push_req(CMD_INSERT, 32'hAAAA_AAAA);
		push_req(CMD_REMOVE, 32'h5555_5554);
		push_req(CMD_INSERT, 32'hFFFF_FFFF);
		push_req(CMD_REMOVE, 32'h8000_0000);
		push_req(CMD_INSERT, 32'h7FFF_FFFF);
		drain();

		// fill the table, then new keys must be refused
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
			push_req(CMD_INSERT, 32'h1000_0000 + i);
		push_req(CMD_INSERT, 32'h1000_0000);
		push_req(CMD_REMOVE, 32'h1000_0001);
		push_req(CMD_INSERT, 32'h2000_0000);
		push_req(CMD_INSERT, 32'h2000_0001);
		push_req(CMD_REMOVE, 32'h1000_0000);
		drain();
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
			push_req(CMD_REMOVE, 32'h1000_0000 + i);
		push_req(CMD_REMOVE, 32'h2000_0000);
		push_req(CMD_REMOVE, 32'hFFFF_FFFF);
		push_req(CMD_REMOVE, 32'h7FFF_FFFF);
		drain();

		// random mix over a key pool larger than the table
		// one block runs with no idling on either side
		for (int b = 0; b < 8; b++) begin
			if (b == 1)
				rx_hold_kick++;
			gaps_on = (b != 4);
			queue_random_block(250, mix[b]);
			if (b == 2 || b == 5)
				drain();
			else
				while (pending_reqs.size() > 20)
					@(posedge clk);
		end
		drain();
		gaps_on = 1'b1;

		repeat (10) @(posedge clk);
		if (fail_cnt == 0 && expected_resps.size() == 0) begin
			$display("counted_key_table_tb OK");
		end else begin
			$display("counted_key_table_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== counted_key_table.f =====
hw/rtl/ckt_pkg.sv
hw/rtl/ckt_entry.sv
hw/rtl/counted_key_table.sv
sim/counted_key_table_tb.sv
